[rtl/hmdm_pkg.sv]
package hmdm_pkg;

    localparam int MAX_DESCRIPTORS_DEF = 32;
    localparam int DESC_WORDS_DEF      = 8;
    localparam int NUM_LANES_DEF       = 4;

    localparam int DESC_BITS  = 256;
    localparam int PART_BITS  = 64;
    localparam int WORD_BITS  = 32;
    localparam int MAX_WORDS  = DESC_BITS / WORD_BITS;
    localparam int WCNT_W     = 6;
    localparam int DIST_W     = 9;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 6;

    // Above any real distance; seeds the running minimum.
    localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(257);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_lane_ctrl;

    typedef struct packed {
        logic busy;
        logic dist_valid;
    } t_lane_stat;

    function automatic logic [WCNT_W-1:0] popcount32(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [WORD_BITS-1:0] c;
        a = v - ((v >> 1) & 32'h5555_5555);
        b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
        c = (b + (b >> 4)) & 32'h0F0F_0F0F;
        return WCNT_W'(c[7:0]) + WCNT_W'(c[15:8]) + WCNT_W'(c[23:16]) + WCNT_W'(c[31:24]);
    endfunction

endpackage

[rtl/hmdm_in_if.sv]
interface hmdm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [hmdm_pkg::CMD_W-1:0]            command;
    logic [hmdm_pkg::PART_BITS-1:0]        desc_part0;
    logic [hmdm_pkg::PART_BITS-1:0]        desc_part1;
    logic [hmdm_pkg::PART_BITS-1:0]        desc_part2;
    logic [hmdm_pkg::PART_BITS-1:0]        desc_part3;

    modport source (output valid, command, desc_part0, desc_part1, desc_part2, desc_part3,
                    input ready);
    modport sink   (input valid, command, desc_part0, desc_part1, desc_part2, desc_part3,
                    output ready);
endinterface

[rtl/hmdm_out_if.sv]
interface hmdm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [hmdm_pkg::DIST_W-1:0]           min_distance;
    logic [hmdm_pkg::STATUS_W-1:0]         status;
    logic [hmdm_pkg::OUT_CNT_W-1:0]        stored_count;

    modport source (output valid, min_distance, status, stored_count, input ready);
    modport sink   (input valid, min_distance, status, stored_count, output ready);
endinterface

[rtl/hmdm_ram.sv]
module hmdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/hmdm_lane.sv]
module hmdm_lane #(
    parameter int BANK_DEPTH = 8,
    parameter int DESC_WORDS = hmdm_pkg::DESC_WORDS_DEF,
    localparam int AB        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  hmdm_pkg::t_lane_ctrl             i_ctrl,
    input  logic [AB-1:0]                    i_wr_addr,
    input  logic [hmdm_pkg::DESC_BITS-1:0]   i_wr_data,
    input  logic [AB-1:0]                    i_rd_addr,
    input  logic [hmdm_pkg::DESC_BITS-1:0]   i_query,
    output hmdm_pkg::t_lane_stat             o_stat,
    output logic [hmdm_pkg::DIST_W-1:0]      o_dist
);
    localparam int MW = hmdm_pkg::MAX_WORDS;
    localparam int WB = hmdm_pkg::WORD_BITS;

    logic [hmdm_pkg::DESC_BITS-1:0] w_rd_data;
    logic                           r_v1;
    logic                           r_v2;
    logic                           r_v3;
    logic [hmdm_pkg::WCNT_W-1:0]    r_wcnt [MW];
    logic [hmdm_pkg::WCNT_W-1:0]    n_wcnt [MW];
    logic [hmdm_pkg::DIST_W-1:0]    r_dist;
    logic [hmdm_pkg::DIST_W-1:0]    n_dist;

    hmdm_ram #(
        .WIDTH (hmdm_pkg::DESC_BITS),
        .DEPTH (BANK_DEPTH)
    ) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctrl.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_ctrl.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // per-word counts; words past DESC_WORDS do not take part
    always_comb begin
        for (int w = 0; w < MW; w++) begin
            if (w < DESC_WORDS) begin
                n_wcnt[w] = hmdm_pkg::popcount32(w_rd_data[w*WB +: WB] ^ i_query[w*WB +: WB]);
            end else begin
                n_wcnt[w] = '0;
            end
        end
    end

    always_comb begin
        n_dist = '0;
        for (int w = 0; w < MW; w++) begin
            n_dist = n_dist + hmdm_pkg::DIST_W'(r_wcnt[w]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (r_v1) begin
            r_wcnt <= n_wcnt;
        end
        if (r_v2) begin
            r_dist <= n_dist;
        end
    end

    assign o_stat.busy       = r_v1 | r_v2 | r_v3;
    assign o_stat.dist_valid = r_v3;
    assign o_dist            = r_dist;
endmodule

[rtl/hmdm_merge.sv]
module hmdm_merge #(
    parameter int NUM_LANES = hmdm_pkg::NUM_LANES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_start,
    input  hmdm_pkg::t_lane_stat             i_stat [NUM_LANES],
    input  logic [hmdm_pkg::DIST_W-1:0]      i_dist [NUM_LANES],
    output logic [hmdm_pkg::DIST_W-1:0]      o_min
);
    logic [hmdm_pkg::DIST_W-1:0] r_min;
    logic [hmdm_pkg::DIST_W-1:0] n_min;

    always_comb begin
        n_min = r_min;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (i_stat[l].dist_valid && (i_dist[l] < n_min)) begin
                n_min = i_dist[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_min <= hmdm_pkg::DIST_INIT;
        end else begin
            r_min <= n_min;
        end
    end

    assign o_min = r_min;
endmodule

[rtl/hamming_min_descriptor_match.sv]
// Descriptor store with nearest-match query. Each input item carries a command: clear,
// load of one 256-bit descriptor (written into the bank of the lane that owns the next
// free slot), or query. A query reads the NUM_LANES banks in parallel, one row per cycle
// and only slots below stored_count, over ceil(stored_count / NUM_LANES) rows; each row
// goes through read, popcount, sum and merge stages. A query of an empty store reads
// nothing and reports the empty status. One item is handled at a time; the result
// register lets the next item in as soon as the result is taken. Stored descriptors
// are kept across a clear; only the count is reset.
module hamming_min_descriptor_match #(
    parameter int MAX_DESCRIPTORS = hmdm_pkg::MAX_DESCRIPTORS_DEF,
    parameter int DESC_WORDS      = hmdm_pkg::DESC_WORDS_DEF,
    parameter int NUM_LANES       = hmdm_pkg::NUM_LANES_DEF   // power of two, at least 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hmdm_in_if.sink   i_in,
    hmdm_out_if.source o_out
);
    localparam int LB         = $clog2(NUM_LANES);
    localparam int BANK_DEPTH = (MAX_DESCRIPTORS + NUM_LANES - 1) / NUM_LANES;
    localparam int AB         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int CW         = $clog2(MAX_DESCRIPTORS + 1);
    localparam int IW         = CW + LB + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                             r_state;
    logic [CW-1:0]                      r_count;
    logic [AB-1:0]                      r_pass;
    logic [hmdm_pkg::DESC_BITS-1:0]     r_query;
    logic                               r_out_valid;
    logic [hmdm_pkg::DIST_W-1:0]        r_out_min;
    logic [hmdm_pkg::STATUS_W-1:0]      r_out_status;
    logic [hmdm_pkg::OUT_CNT_W-1:0]     r_out_count;

    logic                               w_accept;
    logic                               w_full;
    logic [hmdm_pkg::DESC_BITS-1:0]     w_desc;
    logic [IW-1:0]                      w_wr_idx;
    logic [AB-1:0]                      w_wr_addr;
    logic [IW-1:0]                      w_pass_base;
    logic                               w_last_pass;
    logic                               w_busy;
    logic                               w_start;

    hmdm_pkg::t_lane_ctrl               w_ctrl [NUM_LANES];
    hmdm_pkg::t_lane_stat               w_stat [NUM_LANES];
    logic [hmdm_pkg::DIST_W-1:0]        w_dist [NUM_LANES];
    logic [hmdm_pkg::DIST_W-1:0]        w_min;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count >= CW'(MAX_DESCRIPTORS));
    assign w_desc     = {i_in.desc_part3, i_in.desc_part2, i_in.desc_part1, i_in.desc_part0};
    assign w_start    = w_accept && (i_in.command == hmdm_pkg::CMD_QUERY);

    // slot i lives in bank i mod NUM_LANES, row i / NUM_LANES
    assign w_wr_idx    = IW'(r_count);
    assign w_wr_addr   = AB'(w_wr_idx >> LB);
    assign w_pass_base = IW'(r_pass) << LB;
    assign w_last_pass = (w_pass_base + IW'(NUM_LANES)) >= IW'(r_count);

    always_comb begin
        w_busy = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            w_ctrl[l].wr_en = w_accept && (i_in.command == hmdm_pkg::CMD_LOAD) && !w_full
                              && (w_wr_idx[LB-1:0] == LB'(l));
            w_ctrl[l].rd_en = (r_state == S_RUN) && ((w_pass_base | IW'(l)) < IW'(r_count));
            w_busy          = w_busy | w_stat[l].busy;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        hmdm_lane #(
            .BANK_DEPTH (BANK_DEPTH),
            .DESC_WORDS (DESC_WORDS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl[g]),
            .i_wr_addr (w_wr_addr),
            .i_wr_data (w_desc),
            .i_rd_addr (r_pass),
            .i_query   (r_query),
            .o_stat    (w_stat[g]),
            .o_dist    (w_dist[g])
        );
    end

    hmdm_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_stat  (w_stat),
        .i_dist  (w_dist),
        .o_min   (w_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // an accepted item sets or clears the result valid itself
            if (r_out_valid && o_out.ready && !w_accept) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_out_min <= '0;
                        case (i_in.command)
                            hmdm_pkg::CMD_CLEAR: begin
                                r_count      <= '0;
                                r_out_status <= hmdm_pkg::ST_OK;
                                r_out_count  <= '0;
                                r_out_valid  <= 1'b1;
                            end
                            hmdm_pkg::CMD_LOAD: begin
                                r_out_valid <= 1'b1;
                                if (w_full) begin
                                    r_out_status <= hmdm_pkg::ST_FULL;
                                    r_out_count  <= hmdm_pkg::OUT_CNT_W'(r_count);
                                end else begin
                                    r_count      <= r_count + 1'b1;
                                    r_out_status <= hmdm_pkg::ST_OK;
                                    r_out_count  <= hmdm_pkg::OUT_CNT_W'(r_count + 1'b1);
                                end
                            end
                            hmdm_pkg::CMD_QUERY: begin
                                if (r_count == '0) begin
                                    r_out_status <= hmdm_pkg::ST_EMPTY;
                                    r_out_count  <= hmdm_pkg::OUT_CNT_W'(r_count);
                                    r_out_valid  <= 1'b1;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_query     <= w_desc;
                                    r_pass      <= '0;
                                    r_state     <= S_RUN;
                                end
                            end
                            default: begin
                                // unused command: report and change nothing
                                r_out_status <= hmdm_pkg::ST_OK;
                                r_out_count  <= hmdm_pkg::OUT_CNT_W'(r_count);
                                r_out_valid  <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (w_last_pass) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_pass <= r_pass + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // lanes empty means the last distance is already in the merge
                    if (!w_busy) begin
                        r_out_min    <= w_min;
                        r_out_status <= hmdm_pkg::ST_OK;
                        r_out_count  <= hmdm_pkg::OUT_CNT_W'(r_count);
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.min_distance = r_out_min;
    assign o_out.status       = r_out_status;
    assign o_out.stored_count = r_out_count;
endmodule
